### hdl/mbr_pkg.sv
// Shared types, constants and helpers for the MSB-first bit reader.
package mbr_pkg;

    // Byte store geometry
    localparam int MAX_BYTES = 4096;
    localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Read request limits
    localparam int MAX_READ  = 32;
    localparam int WANT_W    = 6;
    localparam int OFF_W     = 4;
    localparam int BYTE_BITS = 8;

    // Command queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    // Command codes on the input word
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        byte_in;
        logic [WANT_W-1:0] bit_count;
    } t_mbr_in;

    typedef struct packed {
        logic [31:0] value;
        logic        end_of_stream;
        logic [15:0] bits_remaining;
    } t_mbr_out;

    // Classified operation carried from front to back
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_READ,
        OP_NOP
    } t_mbr_op;

    typedef struct packed {
        t_mbr_op           op;
        logic [7:0]        data;
        logic [WANT_W-1:0] want;
    } t_mbr_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_mbr_state;

    // Stream pointers exported for checking
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] pos;
        logic [OFF_W-1:0] off;
    } t_mbr_stat;

    // Unread bits: zero at end of stream, saturated to 16 bits
    function automatic logic [15:0] unread_bits(input logic [CNT_W-1:0] count,
                                                input logic [CNT_W-1:0] pos,
                                                input logic [OFF_W-1:0] off);
        logic [CNT_W-1:0] whole;
        logic [CNT_W+3:0] r;
        whole = count - pos - CNT_W'(1);
        r     = ((CNT_W+4)'(whole) << 3) + (CNT_W+4)'(off);
        if (pos >= count) begin
            return 16'd0;
        end else if (r > (CNT_W+4)'(17'h0FFFF)) begin
            return 16'hFFFF;
        end else begin
            return 16'(r);
        end
    endfunction

endpackage

### hdl/mbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mbr_front.sv
// Front end: takes command words, classifies them and queues them for the back end.
module mbr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mbr_pkg::t_mbr_in    i_cmd,
    output logic                o_valid,
    input  logic                i_take,
    output mbr_pkg::t_mbr_entry o_entry
);

    mbr_pkg::t_mbr_entry             r_q [mbr_pkg::Q_DEPTH];
    logic [mbr_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [mbr_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [mbr_pkg::Q_CNT_W-1:0]     r_cnt;
    mbr_pkg::t_mbr_entry             cls;
    logic                            wr_en;
    logic                            rd_en;

    // Decode the command word and clamp oversized read lengths
    always_comb begin
        cls.data = i_cmd.byte_in;
        cls.want = i_cmd.bit_count;
        case (i_cmd.cmd)
            mbr_pkg::CMD_CLEAR:  cls.op = mbr_pkg::OP_CLEAR;
            mbr_pkg::CMD_APPEND: cls.op = mbr_pkg::OP_APPEND;
            mbr_pkg::CMD_READ:   cls.op = mbr_pkg::OP_READ;
            default:             cls.op = mbr_pkg::OP_NOP;
        endcase
        if (i_cmd.bit_count > mbr_pkg::WANT_W'(mbr_pkg::MAX_READ)) begin
            cls.want = mbr_pkg::WANT_W'(mbr_pkg::MAX_READ);
        end
    end

    assign full    = (r_cnt == mbr_pkg::Q_CNT_W'(mbr_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr_en   = push && !full;
    assign rd_en   = i_take && o_valid;
    assign o_entry = r_q[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    // Queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + mbr_pkg::Q_PTR_W'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + mbr_pkg::Q_PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + mbr_pkg::Q_CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - mbr_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

### hdl/mbr_back.sv
// Back end: executes clear, append and read commands against the byte store.
module mbr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_take,
    input  mbr_pkg::t_mbr_entry i_entry,
    output logic                empty,
    input  logic                pop,
    output mbr_pkg::t_mbr_out   o_res,
    output mbr_pkg::t_mbr_stat  o_stat
);

    localparam int AW = mbr_pkg::ADDR_W;
    localparam int CW = mbr_pkg::CNT_W;
    localparam int OW = mbr_pkg::OFF_W;
    localparam int WW = mbr_pkg::WANT_W;

    mbr_pkg::t_mbr_state r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_pos,   n_pos;
    logic [OW-1:0]       r_off,   n_off;
    logic [WW-1:0]       r_want,  n_want;
    logic [31:0]         r_acc,   n_acc;
    logic                r_out_valid, n_out_valid;
    mbr_pkg::t_mbr_out   r_out,   n_out;

    logic                ram_we;
    logic [7:0]          ram_rdata;

    // Bit extraction step signals
    logic [OW-1:0]       take;
    logic [OW-1:0]       off_left;
    logic [7:0]          mask;
    logic [7:0]          bits;
    logic [CW-1:0]       step_pos;
    logic [OW-1:0]       step_off;
    logic [WW-1:0]       step_want;
    logic                step_done;
    logic                out_free;
    logic                start_empty_read;

    mbr_ram #(
        .WIDTH (8),
        .DEPTH (mbr_pkg::MAX_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_entry.data),
        .i_raddr (n_pos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free         = !r_out_valid || pop;
    assign start_empty_read = (i_entry.want == '0) || (r_pos >= r_count);

    // One step over the current byte: take up to the bits left in it
    always_comb begin
        take      = (r_want > WW'(r_off)) ? r_off : OW'(r_want);
        off_left  = r_off - take;
        mask      = 8'((9'd1 << take) - 9'd1);
        bits      = (ram_rdata >> off_left) & mask;
        step_want = r_want - WW'(take);
        if (off_left == '0) begin
            step_off = OW'(mbr_pkg::BYTE_BITS);
            step_pos = r_pos + CW'(1);
        end else begin
            step_off = off_left;
            step_pos = r_pos;
        end
        step_done = (step_want == '0) || (step_pos >= r_count);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_entry.op == mbr_pkg::OP_READ && !start_empty_read) begin
                        n_state = mbr_pkg::ST_READ;
                    end else begin
                        n_state = mbr_pkg::ST_DONE;
                    end
                end
            end
            mbr_pkg::ST_READ: begin
                if (step_done) begin
                    n_state = mbr_pkg::ST_DONE;
                end
            end
            mbr_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = mbr_pkg::ST_IDLE;
                end
            end
            default: n_state = mbr_pkg::ST_IDLE;
        endcase
    end

    // Datapath and handshake outputs
    always_comb begin
        o_take      = 1'b0;
        ram_we      = 1'b0;
        n_count     = r_count;
        n_pos       = r_pos;
        n_off       = r_off;
        n_want      = r_want;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        case (r_state)
            mbr_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    n_acc  = '0;
                    n_want = i_entry.want;
                    case (i_entry.op)
                        mbr_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_pos   = '0;
                            n_off   = OW'(mbr_pkg::BYTE_BITS);
                        end
                        mbr_pkg::OP_APPEND: begin
                            if (r_count < CW'(mbr_pkg::MAX_BYTES)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mbr_pkg::ST_READ: begin
                n_acc  = (r_acc << take) | 32'(bits);
                n_want = step_want;
                n_pos  = step_pos;
                n_off  = step_off;
            end
            mbr_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.value          = r_acc;
                    n_out.end_of_stream  = (r_pos >= r_count);
                    n_out.bits_remaining = mbr_pkg::unread_bits(r_count, r_pos, r_off);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbr_pkg::ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_off       <= OW'(mbr_pkg::BYTE_BITS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_want <= n_want;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    assign empty        = !r_out_valid;
    assign o_res        = r_out;
    assign o_stat.count = r_count;
    assign o_stat.pos   = r_pos;
    assign o_stat.off   = r_off;

endmodule

### hdl/msb_first_bit_reader.sv
// Top level of the MSB-first bit reader: front queue, execution back end, checks.
//
//   Channel   Handshake         Payload    Word moved
//   command   push / full       i_cmd      one command: clear, append or read
//   result    pop / empty       o_res      value, end of stream, bits remaining
//
// The back end takes and decodes a queued command when it is idle, then loads the
// result register from its done state once that register is free. A read that moves
// bits steps through the bytes it touches (1 to 5) in the read state, one byte at a
// time, set by the byte RAM's single registered read port. Reset clears the stream
// to empty with a fresh byte. A full result register stalls the back end; the
// two-word front queue keeps accepting meanwhile until it is full.
module msb_first_bit_reader (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  mbr_pkg::t_mbr_in  i_cmd,
    output logic              empty,
    input  logic              pop,
    output mbr_pkg::t_mbr_out o_res
);

    logic                q_valid;
    logic                q_take;
    mbr_pkg::t_mbr_entry q_entry;
    mbr_pkg::t_mbr_stat  stat;

    mbr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_cmd   (i_cmd),
        .o_valid (q_valid),
        .i_take  (q_take),
        .o_entry (q_entry)
    );

    mbr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_take  (q_take),
        .i_entry (q_entry),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res),
        .o_stat  (stat)
    );

    // Bit offset always names 1 to 8 unread bits of the current byte
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.off != '0) && (stat.off <= mbr_pkg::OFF_W'(mbr_pkg::BYTE_BITS)))
        else $error("bit offset out of range");

    // Read position never passes the stored byte count
    a_pos_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pos <= stat.count)
        else $error("read position beyond byte count");

    // Byte count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= mbr_pkg::CNT_W'(mbr_pkg::MAX_BYTES))
        else $error("byte count beyond capacity");

    // End of stream exactly when no bits remain
    a_eos_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_res.end_of_stream == (o_res.bits_remaining == 16'd0)))
        else $error("end of stream disagrees with remaining count");

endmodule
